[src/bce_pkg.sv]
// ----------------------------------------------------------------------------
// bce_pkg: shared types, constants and lookup tables
// LiPo discharge curve, field widths, register indexes and sequencer states
// for the battery charge estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package bce_pkg;

    localparam int ADC_W        = 12;  // width of the sample field
    localparam int FS_W         = 13;  // full_scale_mv register
    localparam int BIAS_W       = 10;  // bias_mv register
    localparam int MV_W         = 14;  // millivolt values
    localparam int PCT_W        = 7;   // percentages
    localparam int TBL_MV_W     = 13;  // table millivolts
    localparam int TBL_IDX_W    = 5;   // table index, up to 32 entries
    localparam int TABLE_STORED = 21;
    localparam int PROD_W       = FS_W + ADC_W;
    localparam int NUM_W        = MV_W + PCT_W;
    localparam int CFG_IDX_W    = 1;

    localparam int DEF_TABLE_ENTRIES = 21;
    localparam int DEF_ADC_BITS      = 12;

    localparam logic [FS_W-1:0]   FS_RESET   = FS_W'(6600);
    localparam logic [BIAS_W-1:0] BIAS_RESET = BIAS_W'(200);
    localparam logic [PCT_W-1:0]  PCT_MAX    = PCT_W'(100);
    localparam logic [MV_W-1:0]   MV_MAX     = {MV_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS       = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_VOLT,
        ST_SEARCH,
        ST_DIFF,
        ST_MULT,
        ST_DIVIDE,
        ST_PCT,
        ST_DONE
    } state_t;

    // Discharge curve, full charge first
    function automatic logic [TBL_MV_W-1:0] lipo_mv(input logic [TBL_IDX_W-1:0] idx);
        logic [TBL_MV_W-1:0] v;
        case (idx)
            5'd0:    v = TBL_MV_W'(4200);
            5'd1:    v = TBL_MV_W'(4150);
            5'd2:    v = TBL_MV_W'(4110);
            5'd3:    v = TBL_MV_W'(4080);
            5'd4:    v = TBL_MV_W'(4020);
            5'd5:    v = TBL_MV_W'(3980);
            5'd6:    v = TBL_MV_W'(3950);
            5'd7:    v = TBL_MV_W'(3910);
            5'd8:    v = TBL_MV_W'(3870);
            5'd9:    v = TBL_MV_W'(3850);
            5'd10:   v = TBL_MV_W'(3840);
            5'd11:   v = TBL_MV_W'(3820);
            5'd12:   v = TBL_MV_W'(3800);
            5'd13:   v = TBL_MV_W'(3790);
            5'd14:   v = TBL_MV_W'(3770);
            5'd15:   v = TBL_MV_W'(3750);
            5'd16:   v = TBL_MV_W'(3730);
            5'd17:   v = TBL_MV_W'(3710);
            5'd18:   v = TBL_MV_W'(3690);
            5'd19:   v = TBL_MV_W'(3610);
            5'd20:   v = TBL_MV_W'(3270);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [PCT_W-1:0] lipo_pct(input logic [TBL_IDX_W-1:0] idx);
        logic [PCT_W-1:0] p;
        case (idx)
            5'd0:    p = PCT_W'(100);
            5'd1:    p = PCT_W'(95);
            5'd2:    p = PCT_W'(90);
            5'd3:    p = PCT_W'(85);
            5'd4:    p = PCT_W'(80);
            5'd5:    p = PCT_W'(75);
            5'd6:    p = PCT_W'(70);
            5'd7:    p = PCT_W'(65);
            5'd8:    p = PCT_W'(60);
            5'd9:    p = PCT_W'(55);
            5'd10:   p = PCT_W'(50);
            5'd11:   p = PCT_W'(45);
            5'd12:   p = PCT_W'(40);
            5'd13:   p = PCT_W'(35);
            5'd14:   p = PCT_W'(30);
            5'd15:   p = PCT_W'(25);
            5'd16:   p = PCT_W'(20);
            5'd17:   p = PCT_W'(15);
            5'd18:   p = PCT_W'(10);
            5'd19:   p = PCT_W'(5);
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

[src/battery_charge_estimator_unit.sv]
// ----------------------------------------------------------------------------
// battery_charge_estimator_unit: LiPo voltage and state-of-charge estimator
// Scales ADC words to millivolts, interpolates the discharge curve and
// smooths both values by averaging each with its previous smoothed value.
// ----------------------------------------------------------------------------
// A word goes from acceptance to result through two states that scale it,
// one compare per table entry while walking down the discharge curve, then
// a 21-step restoring division for the interpolation, and back to idle;
// at or below the last entry the division is skipped. The walk and the
// divider share a single subtractor; in_ready is low while a word is in
// work. A finished result sits in the output register and the next word is
// accepted while it waits. Configuration writes are taken at any time and
// should be made only while the block is idle.
`default_nettype none

module battery_charge_estimator_unit #(
    parameter int TABLE_ENTRIES = bce_pkg::DEF_TABLE_ENTRIES,
    parameter int ADC_BITS      = bce_pkg::DEF_ADC_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [bce_pkg::ADC_W-1:0]      adc_sample,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [bce_pkg::MV_W-1:0]            voltage_mv,
    output logic [bce_pkg::PCT_W-1:0]           charge_percent,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bce_pkg::FS_W-1:0]       cfg_data
);
    import bce_pkg::*;

    localparam int TABLE_USED = (TABLE_ENTRIES < TABLE_STORED) ? TABLE_ENTRIES : TABLE_STORED;
    localparam int IDX_W      = $clog2(TABLE_USED + 1);
    localparam int MASK_BITS  = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
    localparam logic [ADC_W-1:0] SAMPLE_MASK = ADC_W'((32'd1 << MASK_BITS) - 32'd1);
    localparam int CNT_W      = $clog2(NUM_W);
    localparam int SUB_W      = TBL_MV_W + 1;

    state_t state_reg, state_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 primed_reg, primed_next;
    logic [MV_W-1:0]      avg_v_reg, avg_v_next;
    logic [PCT_W-1:0]     avg_p_reg, avg_p_next;
    logic [FS_W-1:0]      fs_reg;
    logic [BIAS_W-1:0]    bias_reg;

    logic [ADC_W-1:0]     sample_reg, sample_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [MV_W-1:0]      mv_reg, mv_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [TBL_MV_W-1:0]  rem_reg, rem_next;
    logic [TBL_MV_W-1:0]  div_reg, div_next;
    logic [PCT_W-1:0]     dp_reg, dp_next;
    logic [PCT_W-1:0]     pct_reg, pct_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    // shared subtractor
    logic [SUB_W-1:0]     sub_a, sub_b;
    logic [SUB_W:0]       sub_res;
    logic                 borrow;

    logic [TBL_IDX_W-1:0] tidx, tidx_hi;
    logic [PROD_W:0]      volt_sum;
    logic [PCT_W:0]       pct_sum;
    logic [MV_W:0]        v_sum;
    logic [PCT_W:0]       p_sum;
    logic                 at_end;
    logic                 out_free;

    assign tidx     = TBL_IDX_W'(idx_reg);
    assign tidx_hi  = TBL_IDX_W'(idx_reg - IDX_W'(1));
    assign at_end   = (idx_reg == IDX_W'(TABLE_USED));
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        case (state_reg)
            ST_SEARCH:
            begin
                sub_a = {1'b0, lipo_mv(tidx)};
                sub_b = mv_reg;
            end
            ST_DIFF:
            begin
                sub_a = mv_reg;
                sub_b = {1'b0, lipo_mv(tidx)};
            end
            ST_DIVIDE:
            begin
                sub_a = {rem_reg, num_reg[NUM_W-1]};
                sub_b = {1'b0, div_reg};
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow  = sub_res[SUB_W];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_SCALE;
            ST_SCALE:
                state_next = ST_VOLT;
            ST_VOLT:
                state_next = ST_SEARCH;
            ST_SEARCH:
                if (at_end)
                    state_next = ST_DONE;
                else if (borrow)
                    state_next = ST_DIFF;
            ST_DIFF:
                state_next = ST_MULT;
            ST_MULT:
                state_next = ST_DIVIDE;
            ST_DIVIDE:
                if (cnt_reg == '0)
                    state_next = ST_PCT;
            ST_PCT:
                state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        sample_next    = sample_reg;
        prod_next      = prod_reg;
        mv_next        = mv_reg;
        idx_next       = idx_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        dp_next        = dp_reg;
        pct_next       = pct_reg;
        cnt_next       = cnt_reg;
        primed_next    = primed_reg;
        avg_v_next     = avg_v_reg;
        avg_p_next     = avg_p_reg;
        out_valid_next = out_valid_reg && !out_ready;

        volt_sum = {1'b0, prod_reg >> ADC_BITS} + (PROD_W + 1)'(bias_reg);
        pct_sum  = {1'b0, num_reg[PCT_W-1:0]} + {1'b0, lipo_pct(tidx)};
        v_sum    = {1'b0, avg_v_reg} + {1'b0, mv_reg};
        p_sum    = {1'b0, avg_p_reg} + {1'b0, pct_reg};

        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    sample_next = adc_sample & SAMPLE_MASK;
            ST_SCALE:
                prod_next = PROD_W'(fs_reg * sample_reg);
            ST_VOLT:
            begin
                if (volt_sum > (PROD_W + 1)'(MV_MAX))
                    mv_next = MV_MAX;
                else
                    mv_next = volt_sum[MV_W-1:0];
                idx_next = '0;
            end
            ST_SEARCH:
                if (at_end)
                    pct_next = '0;
                else if (borrow)
                begin
                    // above the top entry the top segment is extrapolated
                    if (idx_reg == '0)
                        idx_next = IDX_W'(1);
                end
                else
                    idx_next = idx_reg + IDX_W'(1);
            ST_DIFF:
            begin
                num_next = NUM_W'(sub_res[MV_W-1:0]);
                rem_next = '0;
                div_next = lipo_mv(tidx_hi) - lipo_mv(tidx);
                dp_next  = lipo_pct(tidx_hi) - lipo_pct(tidx);
                cnt_next = CNT_W'(NUM_W - 1);
            end
            ST_MULT:
                num_next = NUM_W'(num_reg[MV_W-1:0] * dp_reg);
            ST_DIVIDE:
            begin
                rem_next = borrow ? sub_a[TBL_MV_W-1:0] : sub_res[TBL_MV_W-1:0];
                num_next = {num_reg[NUM_W-2:0], !borrow};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            ST_PCT:
                if (num_reg > NUM_W'(PCT_MAX) || pct_sum > {1'b0, PCT_MAX})
                    pct_next = PCT_MAX;
                else
                    pct_next = pct_sum[PCT_W-1:0];
            ST_DONE:
                if (out_free)
                begin
                    if (primed_reg)
                    begin
                        avg_v_next = v_sum[MV_W:1];
                        avg_p_next = p_sum[PCT_W:1];
                    end
                    else
                    begin
                        avg_v_next = mv_reg;
                        avg_p_next = pct_reg;
                    end
                    primed_next    = 1'b1;
                    out_valid_next = 1'b1;
                end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ready;
            end
        endcase
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign voltage_mv     = avg_v_reg;
    assign charge_percent = avg_p_reg;
    assign cfg_ready      = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            primed_reg    <= 1'b0;
            avg_v_reg     <= '0;
            avg_p_reg     <= '0;
            fs_reg        <= FS_RESET;
            bias_reg      <= BIAS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            primed_reg    <= primed_next;
            avg_v_reg     <= avg_v_next;
            avg_p_reg     <= avg_p_next;
            if (cfg_valid && cfg_index == REG_FULL_SCALE)
                fs_reg <= cfg_data;
            if (cfg_valid && cfg_index == REG_BIAS)
                bias_reg <= cfg_data[BIAS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        prod_reg   <= prod_next;
        mv_reg     <= mv_next;
        idx_reg    <= idx_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        dp_reg     <= dp_next;
        pct_reg    <= pct_next;
        cnt_reg    <= cnt_next;
    end

`ifndef SYNTHESIS
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (avg_p_reg <= PCT_MAX))
        else $error("charge percent above full");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (div_reg != '0))
        else $error("interpolation divisor is zero");

    a_primed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> primed_reg)
        else $error("result shown before first reading");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (idx_reg <= IDX_W'(TABLE_USED)))
        else $error("table walk past end");
`endif

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for battery_charge_estimator_unit
// Drives ADC words through the valid/ready input, reprograms the scale and
// bias registers between phases, and checks every smoothed voltage/percent
// pair against an in-bench estimator of the discharge curve interpolation.
// ----------------------------------------------------------------------------
module testbench;

    import bce_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 60;
    localparam int HOLD_OFF       = 400;
    localparam int CURVE_POINTS   = 21;
    localparam int CURVE_STEP     = 5;   // percent between curve points

    typedef struct packed {
        logic [MV_W-1:0]  volts;
        logic [PCT_W-1:0] pct;
    } reading_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [ADC_W-1:0]     adc_sample;
    logic                 out_valid;
    logic                 out_ready;
    logic [MV_W-1:0]      voltage_mv;
    logic [PCT_W-1:0]     charge_percent;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FS_W-1:0]      cfg_data;

    // discharge curve in mV, full charge first; percent is 100 - 5*i
    int curve_mv [CURVE_POINTS] = '{4200, 4150, 4110, 4080, 4020, 3980, 3950,
                                    3910, 3870, 3850, 3840, 3820, 3800, 3790,
                                    3770, 3750, 3730, 3710, 3690, 3610, 3270};

    // estimator copy of registers and smoothing state
    logic [FS_W-1:0]   cur_full_scale = FS_RESET;
    logic [BIAS_W-1:0] cur_bias       = BIAS_RESET;
    logic              est_primed     = 1'b0;
    logic [MV_W-1:0]   est_volt       = '0;
    logic [PCT_W-1:0]  est_pct        = '0;

    reading_t pending_readings [$];

    int mismatches   = 0;
    int quiet_cycles = 0;
    int tx_max_gap   = 11;
    int rx_max_gap   = 11;
    int rx_hold      = 0;

    battery_charge_estimator_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .adc_sample     (adc_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .voltage_mv     (voltage_mv),
        .charge_percent (charge_percent),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Estimator
    // ------------------------------------------------------------------------
    function automatic int charge_of(input int mv);
        int k;
        int p;
        k = 0;
        while (k < CURVE_POINTS && mv <= curve_mv[k])
            k++;
        // at or below the bottom point
        if (k >= CURVE_POINTS)
            return 0;
        // above the top point the top segment is extrapolated, then capped
        if (k > 0)
            k--;
        p = (mv - curve_mv[k+1]) * CURVE_STEP / (curve_mv[k] - curve_mv[k+1])
            + (100 - CURVE_STEP * (k + 1));
        return (p > 100) ? 100 : p;
    endfunction

    function automatic reading_t smooth_reading(input logic [ADC_W-1:0] s);
        int mv;
        int pct;
        reading_t r;
        mv = ((int'(cur_full_scale) * int'(s)) >> ADC_W) + int'(cur_bias);
        if (mv > int'(MV_MAX))
            mv = int'(MV_MAX);
        pct = charge_of(mv);
        if (!est_primed)
        begin
            est_volt   = MV_W'(mv);
            est_pct    = PCT_W'(pct);
            est_primed = 1'b1;
        end
        else
        begin
            est_volt = MV_W'((int'(est_volt) + mv) >> 1);
            est_pct  = PCT_W'((int'(est_pct) + pct) >> 1);
        end
        r.volts = est_volt;
        r.pct   = est_pct;
        return r;
    endfunction

    // smallest sample that lands at or above a target voltage, given the registers
    function automatic logic [ADC_W-1:0] sample_for_mv(input int target);
        int s;
        if (target <= int'(cur_bias))
            return '0;
        if (cur_full_scale == '0)
            return ADC_W'($urandom_range(0, (1 << ADC_W) - 1));
        s = ((target - int'(cur_bias)) * (1 << ADC_W) + int'(cur_full_scale) - 1)
            / int'(cur_full_scale);
        return (s > (1 << ADC_W) - 1) ? '1 : ADC_W'(s);
    endfunction

    // ------------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [ADC_W-1:0] s);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        adc_sample <= s;
        do @(posedge clk); while (!in_ready);
        pending_readings.push_back(smooth_reading(s));
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [FS_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_FULL_SCALE)
            cur_full_scale = data;
        else
            cur_bias = data[BIAS_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        reading_t want;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            else
                stall = $urandom_range(0, rx_max_gap);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word: voltage_mv %0d charge_percent %0d",
                         $time, voltage_mv, charge_percent);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (voltage_mv !== want.volts)
                begin
                    mismatches++;
                    $display("%0t: voltage_mv expected %0d actual %0d",
                             $time, want.volts, voltage_mv);
                end
                if (charge_percent !== want.pct)
                begin
                    mismatches++;
                    $display("%0t: charge_percent expected %0d actual %0d",
                             $time, want.pct, charge_percent);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset register values; the first word primes the average
    task automatic test_first_reading();
        send_sample('1);
        send_sample('0);
    endtask

    // unity scale so a set of curve points, some neighbors and the ends are hit exactly
    task automatic test_curve_points();
        int points [22];
        wait_for_results();
        write_register(REG_FULL_SCALE, FS_W'(1 << ADC_W));
        write_register(REG_BIAS, FS_W'(200));
        points = '{200, 3270, 3271, 3610, 3609, 3690, 3700, 3750, 3790, 3800, 3840,
                   3850, 3870, 3950, 4020, 4080, 4110, 4150, 4199, 4200, 4201, 4295};
        foreach (points[i])
            send_sample(sample_for_mv(points[i]));
    endtask

    task automatic test_register_extremes();
        wait_for_results();
        write_register(REG_FULL_SCALE, '0);
        write_register(REG_BIAS, '0);
        send_sample('1);
        send_sample('0);
        wait_for_results();
        // upper data bits are dropped by the bias register
        write_register(REG_FULL_SCALE, '1);
        write_register(REG_BIAS, '1);
        send_sample('1);
        send_sample('0);
        send_sample('1);
        wait_for_results();
        write_register(REG_BIAS, FS_W'(13'h1C00));
        send_sample('1);
        send_sample(ADC_W'(12'hAAA));
        send_sample(ADC_W'(12'h555));
    endtask

    // no idling, then the sender waits for the pipe to empty and resumes
    task automatic test_back_to_back();
        wait_for_results();
        write_register(REG_FULL_SCALE, FS_W'(6600));
        write_register(REG_BIAS, FS_W'(200));
        tx_max_gap = 0;
        rx_max_gap = 0;
        repeat (40) send_sample(sample_for_mv($urandom_range(3200, 4300)));
        wait_for_results();
        repeat (20) send_sample(sample_for_mv($urandom_range(3200, 4300)));
        tx_max_gap = 11;
        rx_max_gap = 11;
    endtask

    // receiver holds off after its next word while the sender keeps offering
    task automatic test_output_backpressure();
        wait_for_results();
        rx_hold = HOLD_OFF;
        repeat (16) send_sample(sample_for_mv($urandom_range(3200, 4300)));
    endtask

    task automatic test_random_readings();
        logic [ADC_W-1:0] s;
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_for_results();
            write_register(REG_FULL_SCALE, FS_W'($urandom_range(3000, (1 << FS_W) - 1)));
            write_register(REG_BIAS, FS_W'($urandom_range(0, (1 << FS_W) - 1)));
            tx_max_gap = (phase == 2) ? 0 : 11;
            rx_max_gap = (phase == 4) ? 0 : 11;
            repeat (100)
            begin
                // mostly voltages on the curve, the rest anywhere
                if ($urandom_range(0, 3) != 0)
                    s = sample_for_mv($urandom_range(3200, 4300));
                else
                    s = ADC_W'($urandom_range(0, (1 << ADC_W) - 1));
                send_sample(s);
            end
        end
        tx_max_gap = 11;
        rx_max_gap = 11;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        adc_sample = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_FULL_SCALE;
        cfg_data   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_first_reading();
        test_curve_points();
        test_register_extremes();
        test_back_to_back();
        test_output_backpressure();
        test_random_readings();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
